// File: rtl/assert_macros.svh
// assertion macros shared by the parser modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define HRLP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define HRLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/hrlp_pkg.sv
// types, codes and character constants of the request line parser
package hrlp_pkg;

  // parse phases
  typedef enum logic [2:0] {
    PH_METHOD,
    PH_TARGET,
    PH_PROTO,
    PH_MAJOR,
    PH_DOT,
    PH_MINOR,
    PH_TAIL,
    PH_SKIP
  } phase_t;

  // line status codes
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_UNSUPPORTED = 2'd1,
    ST_MALFORMED   = 2'd2
  } status_t;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [2:0] METHOD_LAST_POS = 3'd3;
  localparam logic [2:0] PROTO_LAST_POS  = 3'd4;

  // one result item
  typedef struct packed {
    logic       is_summary;
    logic [7:0] target_char;
    logic [1:0] parse_status;
    logic [3:0] version_major;
    logic [3:0] version_minor;
    logic [7:0] target_length;
  } result_t;

  // "GET " by position
  function automatic logic [7:0] method_char(input logic [1:0] pos);
    logic [7:0] ch;
    case (pos)
      2'd0:    ch = 8'h47;
      2'd1:    ch = 8'h45;
      2'd2:    ch = 8'h54;
      default: ch = CH_SPACE;
    endcase
    return ch;
  endfunction

  // "HTTP/" by position
  function automatic logic [7:0] proto_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h48;
      3'd1:    ch = 8'h54;
      3'd2:    ch = 8'h54;
      3'd3:    ch = 8'h50;
      3'd4:    ch = 8'h2F;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// File: rtl/hrlp_if.sv
// valid/ready channel interfaces for line bytes and parse results
interface hrlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       end_of_line;

  modport source (output valid, output line_byte, output end_of_line, input ready);
  modport sink   (input valid, input line_byte, input end_of_line, output ready);
endinterface

interface hrlp_out_if;
  logic       valid;
  logic       ready;
  logic       is_summary;
  logic [7:0] target_char;
  logic [1:0] parse_status;
  logic [3:0] version_major;
  logic [3:0] version_minor;
  logic [7:0] target_length;

  modport source (output valid, output is_summary, output target_char,
                  output parse_status, output version_major, output version_minor,
                  output target_length, input ready);
  modport sink   (input valid, input is_summary, input target_char,
                  input parse_status, input version_major, input version_minor,
                  input target_length, output ready);
endinterface

// File: rtl/http_request_line_parser.sv
// HTTP request line parser: one line byte per request, target bytes and a summary out
// Takes one byte per clock cycle, sustained, as long as results are taken. A byte is
// held in the input register, then the parse step updates the parse state and any
// result goes into a two-entry output queue, so a result passes the input register and
// the queue register before it appears. The parse step sets the rate; the queue keeps
// bytes flowing while a result waits. Target bytes past TARGET_MAX are dropped; the
// summary comes with the byte flagged end_of_line and the parser then starts over on
// the next line.
module http_request_line_parser #(
  parameter int TARGET_MAX = 255
) (
  input  logic   clk,
  input  logic   rst_n,
  hrlp_in_if.sink    in_ch,
  hrlp_out_if.source out_ch
);

  logic              stage_v_r, stage_v_nxt;
  logic [7:0]        stage_byte_r;
  logic              stage_last_r;
  logic              advance;
  logic              in_take;
  logic              room;
  logic              res_valid;
  hrlp_pkg::result_t res;
  hrlp_pkg::result_t q_data;

  assign advance     = stage_v_r && room;
  assign in_ch.ready = !stage_v_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  // input register
  always_comb begin
    stage_v_nxt = stage_v_r;
    if (in_take) begin
      stage_v_nxt = 1'b1;
    end else if (advance) begin
      stage_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else begin
      stage_v_r <= stage_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stage_byte_r <= in_ch.line_byte;
      stage_last_r <= in_ch.end_of_line;
    end
  end

  // parse step
  hrlp_parse_core #(
    .TARGET_MAX (TARGET_MAX)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (advance),
    .line_byte   (stage_byte_r),
    .end_of_line (stage_last_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  // result queue
  hrlp_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_data  (q_data),
    .room      (room)
  );

  assign out_ch.is_summary    = q_data.is_summary;
  assign out_ch.target_char   = q_data.target_char;
  assign out_ch.parse_status  = q_data.parse_status;
  assign out_ch.version_major = q_data.version_major;
  assign out_ch.version_minor = q_data.version_minor;
  assign out_ch.target_length = q_data.target_length;

endmodule

// File: rtl/hrlp_parse_core.sv
// parse state machine: one byte per take, produces at most one result
`include "assert_macros.svh"

module hrlp_parse_core #(
  parameter int TARGET_MAX = 255
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [7:0]        line_byte,
  input  logic              end_of_line,
  output logic              res_valid,
  output hrlp_pkg::result_t res
);

  localparam int KW = $clog2(TARGET_MAX + 1);
  localparam int EW = (KW > 8) ? KW : 8;

  hrlp_pkg::phase_t  ph_r, ph_nxt;
  hrlp_pkg::status_t status_r, status_nxt;
  logic [2:0]        pos_r, pos_nxt;
  logic [KW-1:0]     kept_r, kept_nxt, kept_upd;
  logic [3:0]        major_r, major_nxt;
  logic [3:0]        minor_r, minor_nxt;
  logic              emit;
  logic              is_digit;
  logic [EW-1:0]     kept_ext;
  logic [7:0]        len_sat;

  assign is_digit = (line_byte >= hrlp_pkg::CH_ZERO) && (line_byte <= hrlp_pkg::CH_NINE);

  // phase and field update for the byte
  always_comb begin
    ph_nxt     = ph_r;
    status_nxt = status_r;
    pos_nxt    = pos_r;
    kept_upd   = kept_r;
    major_nxt  = major_r;
    minor_nxt  = minor_r;
    emit       = 1'b0;
    case (ph_r)
      hrlp_pkg::PH_METHOD: begin
        if (line_byte == hrlp_pkg::method_char(pos_r[1:0])) begin
          if (pos_r == hrlp_pkg::METHOD_LAST_POS) begin
            ph_nxt  = hrlp_pkg::PH_TARGET;
            pos_nxt = 3'd0;
          end else begin
            pos_nxt = pos_r + 3'd1;
          end
        end else begin
          ph_nxt     = hrlp_pkg::PH_SKIP;
          status_nxt = hrlp_pkg::ST_UNSUPPORTED;
        end
      end
      hrlp_pkg::PH_TARGET: begin
        if (line_byte == hrlp_pkg::CH_SPACE) begin
          ph_nxt  = hrlp_pkg::PH_PROTO;
          pos_nxt = 3'd0;
        end else if (!end_of_line && (kept_r < KW'(TARGET_MAX))) begin
          kept_upd = kept_r + KW'(1);
          emit     = 1'b1;
        end
      end
      hrlp_pkg::PH_PROTO: begin
        if ((pos_r <= hrlp_pkg::PROTO_LAST_POS) &&
            (line_byte == hrlp_pkg::proto_char(pos_r))) begin
          if (pos_r == hrlp_pkg::PROTO_LAST_POS) begin
            ph_nxt  = hrlp_pkg::PH_MAJOR;
            pos_nxt = 3'd0;
          end else begin
            pos_nxt = pos_r + 3'd1;
          end
        end else begin
          ph_nxt     = hrlp_pkg::PH_SKIP;
          status_nxt = hrlp_pkg::ST_MALFORMED;
        end
      end
      hrlp_pkg::PH_MAJOR: begin
        if (is_digit) begin
          major_nxt = line_byte[3:0];
          ph_nxt    = hrlp_pkg::PH_DOT;
        end else begin
          ph_nxt     = hrlp_pkg::PH_SKIP;
          status_nxt = hrlp_pkg::ST_MALFORMED;
        end
      end
      hrlp_pkg::PH_DOT: begin
        if (line_byte == hrlp_pkg::CH_DOT) begin
          ph_nxt = hrlp_pkg::PH_MINOR;
        end else begin
          ph_nxt     = hrlp_pkg::PH_SKIP;
          status_nxt = hrlp_pkg::ST_MALFORMED;
        end
      end
      hrlp_pkg::PH_MINOR: begin
        if (is_digit) begin
          minor_nxt = line_byte[3:0];
          ph_nxt    = hrlp_pkg::PH_TAIL;
        end else begin
          ph_nxt     = hrlp_pkg::PH_SKIP;
          status_nxt = hrlp_pkg::ST_MALFORMED;
        end
      end
      default: begin
      end
    endcase
  end

  // reported length saturates at 255
  assign kept_ext = EW'(kept_upd);
  assign len_sat  = (kept_ext > EW'(255)) ? 8'hFF : kept_ext[7:0];

  // result item
  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    kept_nxt  = kept_upd;
    if (end_of_line) begin
      res_valid      = 1'b1;
      res.is_summary = 1'b1;
      if (ph_nxt == hrlp_pkg::PH_TAIL) begin
        res.parse_status  = hrlp_pkg::ST_OK;
        res.version_major = major_nxt;
        res.version_minor = minor_nxt;
      end else if ((ph_nxt == hrlp_pkg::PH_METHOD) ||
                   (status_nxt == hrlp_pkg::ST_UNSUPPORTED)) begin
        res.parse_status = hrlp_pkg::ST_UNSUPPORTED;
      end else begin
        res.parse_status = hrlp_pkg::ST_MALFORMED;
      end
      res.target_length = len_sat;
      kept_nxt          = '0;
    end else if (emit) begin
      res_valid         = 1'b1;
      res.target_char   = line_byte;
      res.target_length = len_sat;
    end
    res_valid = res_valid && take;
  end

  // state registers, back to the start after every line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r     <= hrlp_pkg::PH_METHOD;
      status_r <= hrlp_pkg::ST_OK;
      pos_r    <= 3'd0;
      kept_r   <= '0;
      major_r  <= 4'd0;
      minor_r  <= 4'd0;
    end else if (take) begin
      if (end_of_line) begin
        ph_r     <= hrlp_pkg::PH_METHOD;
        status_r <= hrlp_pkg::ST_OK;
        pos_r    <= 3'd0;
        kept_r   <= '0;
        major_r  <= 4'd0;
        minor_r  <= 4'd0;
      end else begin
        ph_r     <= ph_nxt;
        status_r <= status_nxt;
        pos_r    <= pos_nxt;
        kept_r   <= kept_nxt;
        major_r  <= major_nxt;
        minor_r  <= minor_nxt;
      end
    end
  end

  `HRLP_ASSERT(kept_bound_a, clk, rst_n, kept_r <= KW'(TARGET_MAX), "target count past maximum")
  `HRLP_ASSERT_NEXT(line_restart_a, clk, rst_n, take && end_of_line, (ph_r == hrlp_pkg::PH_METHOD) && (kept_r == '0) && (pos_r == 3'd0), "parser not restarted after line end")

endmodule

// File: rtl/hrlp_out_queue.sv
// two-entry result queue between the parser and the result channel
`include "assert_macros.svh"

module hrlp_out_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  hrlp_pkg::result_t push_data,
  input  logic              out_ready,
  output logic              out_valid,
  output hrlp_pkg::result_t out_data,
  output logic              room
);

  hrlp_pkg::result_t mem_r [2];
  logic [1:0]        count_r, count_nxt;
  logic              wr_ptr_r, rd_ptr_r;
  logic              pop;

  assign out_valid = (count_r != 2'd0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign room      = (count_r != 2'd2) || pop;

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `HRLP_ASSERT(no_overflow_a, clk, rst_n, !push || room, "result pushed into full queue")
  `HRLP_ASSERT_NEXT(fill_step_a, clk, rst_n, push && !pop, count_r == $past(count_r) + 2'd1, "queue count lost a push")

endmodule
